/* hw/rtl/env_sensor_compensation_assert.svh */
// Assertion macros shared by the compensation pipeline.
`ifndef ENV_SENSOR_COMPENSATION_ASSERT_SVH
`define ENV_SENSOR_COMPENSATION_ASSERT_SVH

// Implication checked every clock outside reset.
`define ESC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked outside reset.
`define ESC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* hw/rtl/esc_pkg.sv */
// Shared types, constants and stage count for the compensation pipeline.
package esc_pkg;
  localparam int NStages = 42;
  localparam logic [2:0] RegCalTemp   = 3'd0;
  localparam logic [2:0] RegCalPressA = 3'd1;
  localparam logic [2:0] RegCalPressB = 3'd2;
  localparam logic [2:0] RegCalPressC = 3'd3;
  localparam logic [2:0] RegCalHumA   = 3'd4;
  localparam logic [2:0] RegCalHumB   = 3'd5;

  typedef struct packed {
    logic [15:0] raw_hum;
    logic [19:0] raw_press;
    logic [19:0] raw_temp;
  } in_word_t;

  typedef struct packed {
    logic signed [14:0] temperature_centi;
    logic [16:0] pressure_pa;
    logic        pressure_invalid;
    logic [16:0] humidity_q10;
  } out_word_t;

  typedef struct packed {
    logic [47:0] temp;
    logic [47:0] pa;
    logic [47:0] pb;
    logic [47:0] pc;
    logic [31:0] ha;
    logic [31:0] hb;
  } cal_t;

  function automatic logic [31:0] asr(input logic [31:0] x, input int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul(input logic [31:0] a, input logic [31:0] b);
    return a * b;
  endfunction

  function automatic logic [31:0] sclamp(input logic [31:0] v, input logic [31:0] lo,
                                         input logic [31:0] hi);
    if ($signed(v) < $signed(lo)) return lo;
    if ($signed(hi) < $signed(v)) return hi;
    return v;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction
endpackage

/* hw/rtl/env_sensor_compensation.sv */
// Top level of the environmental sensor compensation pipeline.
//   channel | dir | fields
//   in_     | in  | raw_temp, raw_press, raw_hum
//   out_    | out | temperature_centi, pressure_pa, pressure_invalid, humidity_q10
//   cfg_    | in  | six calibration registers
// One word enters per cycle while the pipe advances; each passes the front stages,
// the 32-stage divider and the back stages. The whole pipe advances when the
// output register is empty or taken. Reset (synchronous) clears valid bits and
// the calibration registers.
module env_sensor_compensation (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // raw_temp[19:0], raw_press[39:20], raw_hum[55:40]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,  // temperature_centi[14:0], pressure_pa[31:15],
                                  // pressure_invalid[32], humidity_q10[49:33]
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  import esc_pkg::*;
  `include "env_sensor_compensation_assert.svh"

  localparam int Lat = NStages;
  cal_t cal_r;
  logic adv;
  logic [Lat-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegCalTemp:   cal_r.temp <= cfg_data;
        RegCalPressA: cal_r.pa <= cfg_data;
        RegCalPressB: cal_r.pb <= cfg_data;
        RegCalPressC: cal_r.pc <= cfg_data;
        RegCalHumA:   cal_r.ha <= cfg_data[31:0];
        RegCalHumB:   cal_r.hb <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign adv = !out_tvalid || out_tready;
  assign in_tready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[Lat-2:0], in_tvalid};
  end
  assign out_tvalid = vld_r[Lat-1];

  // coefficients
  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, cal_r.temp[15:0]};
  assign t2 = sx16(cal_r.temp[31:16]);
  assign t3 = sx16(cal_r.temp[47:32]);
  assign p1 = {16'd0, cal_r.pa[15:0]};
  assign p2 = sx16(cal_r.pa[31:16]);
  assign p3 = sx16(cal_r.pa[47:32]);
  assign p4 = sx16(cal_r.pb[15:0]);
  assign p5 = sx16(cal_r.pb[31:16]);
  assign p6 = sx16(cal_r.pb[47:32]);
  assign p7 = sx16(cal_r.pc[15:0]);
  assign p8 = sx16(cal_r.pc[31:16]);
  assign p9 = sx16(cal_r.pc[47:32]);
  assign h1 = {24'd0, cal_r.ha[7:0]};
  assign h2 = sx16(cal_r.ha[23:8]);
  assign h3 = {24'd0, cal_r.ha[31:24]};
  assign h4 = {{20{cal_r.hb[11]}}, cal_r.hb[11:0]};
  assign h5 = {{20{cal_r.hb[23]}}, cal_r.hb[23:12]};
  assign h6 = {{24{cal_r.hb[31]}}, cal_r.hb[31:24]};

  in_word_t iw;
  assign iw = in_tdata;

  // S1: temperature products
  logic [31:0] s1_a_r, s1_qq_r, s1_adcp_r, s1_adch_r;
  always_ff @(posedge clk) if (adv) begin
    s1_a_r <= mul({15'd0, iw.raw_temp[19:3]} - (t1 << 1), t2);
    s1_qq_r <= mul({16'd0, iw.raw_temp[19:4]} - t1, {16'd0, iw.raw_temp[19:4]} - t1);
    s1_adcp_r <= {12'd0, iw.raw_press};
    s1_adch_r <= {16'd0, iw.raw_hum};
  end
  // S2
  logic [31:0] s2_v1_r, s2_m_r, s2_adcp_r, s2_adch_r;
  always_ff @(posedge clk) if (adv) begin
    s2_v1_r <= asr(s1_a_r, 11);
    s2_m_r <= mul(asr(s1_qq_r, 12), t3);
    s2_adcp_r <= s1_adcp_r;
    s2_adch_r <= s1_adch_r;
  end
  // S3: tfine
  logic [31:0] s3_tf_r, s3_adcp_r, s3_adch_r;
  always_ff @(posedge clk) if (adv) begin
    s3_tf_r <= s2_v1_r + asr(s2_m_r, 14);
    s3_adcp_r <= s2_adcp_r;
    s3_adch_r <= s2_adch_r;
  end
  // S4: first products
  logic [31:0] s4_v1_r, s4_qq_r, s4_t5_r, s4_adcp_r, s4_adch_r;
  logic [31:0] s4_h5_r, s4_h6_r, s4_h3_r;
  logic [31:0] pv1, pq, hv;
  assign pv1 = asr(s3_tf_r, 1) - 32'd64000;
  assign pq = asr(pv1, 2);
  assign hv = s3_tf_r - 32'd76800;
  always_ff @(posedge clk) if (adv) begin
    s4_t5_r <= mul(s3_tf_r, 32'd5);
    s4_v1_r <= pv1;
    s4_qq_r <= mul(pq, pq);
    s4_adcp_r <= s3_adcp_r;
    s4_adch_r <= s3_adch_r;
    s4_h5_r <= mul(h5, hv);
    s4_h6_r <= mul(hv, h6);
    s4_h3_r <= mul(hv, h3);
  end
  // S5
  logic [31:0] s5_temp_r, s5_a_r, s5_b_r, s5_c_r, s5_d_r, s5_adcp_r, s5_hq_r, s5_hr_r;
  always_ff @(posedge clk) if (adv) begin
    s5_temp_r <= sclamp(asr(s4_t5_r + 32'd128, 8), 32'hFFFF_F060, 32'd8500);
    s5_a_r <= mul(asr(s4_qq_r, 11), p6);
    s5_b_r <= mul(s4_v1_r, p5) << 1;
    s5_c_r <= mul(p3, asr(s4_qq_r, 13));
    s5_d_r <= mul(p2, s4_v1_r);
    s5_adcp_r <= s4_adcp_r;
    s5_hq_r <= asr((s4_adch_r << 14) - (h4 << 20) - s4_h5_r + 32'd16384, 15);
    s5_hr_r <= mul(asr(s4_h6_r, 10), asr(s4_h3_r, 11) + 32'd32768);
  end
  // S6
  logic [31:0] s6_temp_r, s6_v2_r, s6_v1_r, s6_adcp_r, s6_hq_r, s6_hr_r;
  always_ff @(posedge clk) if (adv) begin
    s6_temp_r <= s5_temp_r;
    s6_v2_r <= asr(s5_a_r + s5_b_r, 2) + (p4 << 16);
    s6_v1_r <= 32'd32768 + asr(asr(s5_c_r, 3) + asr(s5_d_r, 1), 18);
    s6_adcp_r <= s5_adcp_r;
    s6_hq_r <= s5_hq_r;
    s6_hr_r <= mul(asr(s5_hr_r, 10) + 32'd2097152, h2);
  end
  // S7
  logic [31:0] s7_temp_r, s7_v1_r, s7_pn_r, s7_hq_r, s7_hr_r;
  always_ff @(posedge clk) if (adv) begin
    s7_temp_r <= s6_temp_r;
    s7_v1_r <= asr(mul(s6_v1_r, p1), 15);
    s7_pn_r <= mul((32'd1048576 - s6_adcp_r) - asr(s6_v2_r, 12), 32'd3125);
    s7_hq_r <= s6_hq_r;
    s7_hr_r <= asr(s6_hr_r + 32'd8192, 14);
  end
  // S8: divider entry, humidity continues alongside
  logic [31:0] dnum, dquo;
  logic dbig;
  assign dbig = s7_pn_r[31];
  assign dnum = dbig ? s7_pn_r : (s7_pn_r << 1);
  esc_div u_div (.clk(clk), .en(adv), .num(dnum), .den(s7_v1_r), .quo(dquo));

  logic [31:0] hum_s7;
  logic [31:0] sd_temp_r [32];
  logic        sd_inv_r [32];
  logic        sd_big_r [32];
  logic [31:0] sd_hum_r [32];
  logic [31:0] hq2, hm;
  assign hm = mul(s7_hq_r, s7_hr_r);
  always_ff @(posedge clk) if (adv) begin
    sd_temp_r[0] <= s7_temp_r;
    sd_inv_r[0] <= (s7_v1_r == '0);
    sd_big_r[0] <= dbig;
    sd_hum_r[0] <= hm;
    sd_hum_r[1] <= asr(mul(hq2, hq2), 7);
    sd_hum_r[2] <= asr(mul(sd_hum_r[1], h1), 4);
    for (int i = 1; i < 32; i++) begin
      sd_temp_r[i] <= sd_temp_r[i-1];
      sd_inv_r[i] <= sd_inv_r[i-1];
      sd_big_r[i] <= sd_big_r[i-1];
    end
    for (int i = 3; i < 32; i++) sd_hum_r[i] <= sd_hum_r[i-1];
  end
  assign hq2 = asr(sd_hum_r[0], 15);
  // hum_s7 is the delayed raw product minus the correction term
  logic [31:0] hraw_r [31];
  always_ff @(posedge clk) if (adv) begin
    hraw_r[0] <= sd_hum_r[0];
    for (int i = 1; i < 31; i++) hraw_r[i] <= hraw_r[i-1];
  end
  assign hum_s7 = hraw_r[30] - sd_hum_r[31];

  // S9: post-divide
  logic [31:0] p_q;
  logic [31:0] s9_p_r, s9_a_r, s9_b_r, s9_temp_r, s9_hum_r;
  logic        s9_inv_r;
  assign p_q = sd_big_r[31] ? (dquo << 1) : dquo;
  always_ff @(posedge clk) if (adv) begin
    s9_p_r <= p_q;
    s9_a_r <= mul({3'd0, p_q[31:3]}, {3'd0, p_q[31:3]}) >> 13;
    s9_b_r <= mul({2'd0, p_q[31:2]}, p8);
    s9_temp_r <= sd_temp_r[31];
    s9_inv_r <= sd_inv_r[31];
    s9_hum_r <= sclamp(hum_s7, 32'd0, 32'd419430400);
  end
  // S10
  logic [31:0] s10_p_r, s10_a_r, s10_b_r, s10_temp_r, s10_hum_r;
  logic        s10_inv_r;
  always_ff @(posedge clk) if (adv) begin
    s10_p_r <= s9_p_r;
    s10_a_r <= mul(p9, s9_a_r);
    s10_b_r <= asr(s9_b_r, 13);
    s10_temp_r <= s9_temp_r;
    s10_inv_r <= s9_inv_r;
    s10_hum_r <= s9_hum_r;
  end
  // S11: output register
  logic [31:0] pf, pc;
  assign pf = s10_p_r + asr(asr(s10_a_r, 12) + s10_b_r + p7, 4);
  assign pc = s10_inv_r ? 32'd0 : sclamp(pf, 32'd0, 32'd131071);
  out_word_t ow_r;
  always_ff @(posedge clk) if (adv) begin
    ow_r.temperature_centi <= s10_temp_r[14:0];
    ow_r.pressure_pa <= pc[16:0];
    ow_r.pressure_invalid <= s10_inv_r;
    ow_r.humidity_q10 <= s10_hum_r[28:12];
  end
  assign out_tdata = {6'd0, ow_r.humidity_q10, ow_r.pressure_invalid, ow_r.pressure_pa,
                      ow_r.temperature_centi};

  `ESC_ASSERT_NXT(a_stall_holds, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
  `ESC_ASSERT_IMP(a_ready_path, !out_tvalid, in_tready)
  `ESC_ASSERT_IMP(a_inv_zero, out_tvalid && out_tdata[32], out_tdata[31:15] == 17'd0)
endmodule

/* hw/rtl/esc_div.sv */
// Pipelined restoring divider, one quotient bit per stage (32 stages).
module esc_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [31:0] quo
);
  logic [31:0] n_r [33];
  logic [31:0] d_r [33];
  logic [32:0] rem_r [33];

  assign n_r[0] = num;
  assign d_r[0] = den;
  assign rem_r[0] = '0;

  for (genvar i = 0; i < 32; i++) begin : g_st
    logic [32:0] sh;
    logic [32:0] df;
    logic [31:0] nn_r;
    logic [31:0] dd_r;
    logic [32:0] rr_r;
    assign sh = {rem_r[i][31:0], n_r[i][31]};
    assign df = sh - {1'b0, d_r[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        dd_r <= d_r[i];
        if (!df[32]) begin
          rr_r <= df;
          nn_r <= {n_r[i][30:0], 1'b1};
        end else begin
          rr_r <= sh;
          nn_r <= {n_r[i][30:0], 1'b0};
        end
      end
    end
    assign n_r[i+1] = nn_r;
    assign d_r[i+1] = dd_r;
    assign rem_r[i+1] = rr_r;
  end

  assign quo = n_r[32];
endmodule
